[rtl/nec_ir_pkg.sv]
`default_nettype none

package nec_ir_pkg;

  localparam int CAP_BITS = 16;
  localparam int REG_BITS = 16;
  localparam int NUM_REGS = 8;
  localparam int IDX_BITS = 3;

  // request codes
  localparam logic [1:0] REQ_TICK      = 2'd0;
  localparam logic [1:0] REQ_EDGE      = 2'd1;
  localparam logic [1:0] REQ_TICK_EDGE = 2'd2;

  // window register indexes
  localparam logic [IDX_BITS-1:0] REG_ZERO_MIN   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_ZERO_MAX   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_ONE_MIN    = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_ONE_MAX    = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_REPEAT_MIN = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_REPEAT_MAX = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_LEADER_MIN = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_LEADER_MAX = 3'd7;

  localparam logic [REG_BITS-1:0] REG_RESET [NUM_REGS] = '{
    16'd300, 16'd800, 16'd1400, 16'd1800, 16'd2100, 16'd2500, 16'd4200, 16'd4700
  };

  localparam logic [7:0] KEY_BITS      = 8'd24;
  localparam logic [7:0] SILENCE_FIRST = 8'd3;
  localparam logic [7:0] SILENCE_LAST  = 8'd9;
  localparam logic [7:0] REPEAT_SKIP   = 8'd3;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [CAP_BITS-1:0] capture_count;
  } ir_in_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       key_valid;
    logic       receiving;
    logic [7:0] repeat_total;
    logic [7:0] bits_seen;
  } ir_out_t;

endpackage

`default_nettype wire

[rtl/nec_ir_pulse_decoder.sv]
`default_nettype none

// NEC infrared pulse decoder.
// in_*  : one request per timer event: a 10 ms overflow tick, a capture edge,
//         or a tick followed by an edge. Edges alternate rising/falling; the
//         falling edge carries the high-pulse width in microseconds.
// out_* : exactly one result per request, in order: last key byte, a strobe
//         when this request completed a 24-bit frame, frame activity and the
//         repeat and bit counters.
// cfg_* : writes the eight pulse-width window bounds (index 0..7, exclusive
//         bounds); always ready, meant to be written while the block is idle.
// A request sits in the input register while the decode, set by the window
// compares and counter updates, is worked out, and lands in the result register
// as soon as that register is free or its result is taken. Throughput is one
// request a cycle while the receiver takes every result.
// If the receiver stalls, the result register holds and the input register
// still takes one more request; ready then drops until the result is taken.
// Synchronous reset empties both registers, clears the decode state and
// reloads the default window bounds.

module nec_ir_pulse_decoder
  import nec_ir_pkg::*;
#(
  parameter int CAPTURE_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ir_in_t              in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ir_out_t                  out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [IDX_BITS-1:0] cfg_index,
  input  wire logic [REG_BITS-1:0] cfg_data
);

  logic [REG_BITS-1:0] regs [NUM_REGS];

  logic   in_q_valid;
  ir_in_t in_q;
  logic   advance;

  logic       await_falling, await_falling_next;
  logic       frame_active, frame_active_next;
  logic [7:0] silence_ticks, silence_ticks_next;
  logic [7:0] bit_shift, bit_shift_next;
  logic [7:0] bit_total, bit_total_next;
  logic [7:0] repeat_count, repeat_count_next;
  logic [7:0] held_key, held_key_next;
  logic       key_latch;

  logic                is_tick, is_edge;
  logic [CAP_BITS-1:0] width;
  logic                in_zero, in_one, in_repeat, in_leader;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  assign cfg_ready = 1'b1;
  assign advance   = in_q_valid && (!out_valid || out_ready);
  assign in_ready  = !in_q_valid || advance;

  always_comb begin
    // bits above the capture timer width are not part of the count
    for (int i = 0; i < CAP_BITS; i++) begin
      width[i] = in_q.capture_count[i] & (i < CAPTURE_WIDTH);
    end
  end

  assign in_zero   = width > regs[REG_ZERO_MIN]   && width < regs[REG_ZERO_MAX];
  assign in_one    = width > regs[REG_ONE_MIN]    && width < regs[REG_ONE_MAX];
  assign in_repeat = width > regs[REG_REPEAT_MIN] && width < regs[REG_REPEAT_MAX];
  assign in_leader = width > regs[REG_LEADER_MIN] && width < regs[REG_LEADER_MAX];

  assign is_tick = in_q.req_type == REQ_TICK || in_q.req_type == REQ_TICK_EDGE;
  assign is_edge = in_q.req_type == REQ_EDGE || in_q.req_type == REQ_TICK_EDGE;

  always_comb begin
    await_falling_next = await_falling;
    frame_active_next  = frame_active;
    silence_ticks_next = silence_ticks;
    bit_shift_next     = bit_shift;
    bit_total_next     = bit_total;
    repeat_count_next  = repeat_count;
    held_key_next      = held_key;
    key_latch          = 1'b0;

    // tick first: frame closes after enough silence
    if (is_tick && frame_active) begin
      if (silence_ticks > SILENCE_FIRST &&
          (repeat_count == 8'd0 || silence_ticks > SILENCE_LAST)) begin
        frame_active_next = 1'b0;
      end
      silence_ticks_next = sat_inc(silence_ticks);
    end

    if (is_edge) begin
      if (!await_falling) begin
        await_falling_next = 1'b1;
        silence_ticks_next = 8'd0;
      end else begin
        await_falling_next = 1'b0;
        if (frame_active_next) begin
          priority if (in_zero) begin
            bit_shift_next = {bit_shift[6:0], 1'b0};
            bit_total_next = sat_inc(bit_total);
          end else if (in_one) begin
            bit_shift_next = {bit_shift[6:0], 1'b1};
            bit_total_next = sat_inc(bit_total);
          end else if (in_repeat) begin
            if (repeat_count > REPEAT_SKIP) begin
              bit_total_next = sat_inc(bit_total);
            end
            repeat_count_next = sat_inc(repeat_count);
          end
        end else if (in_leader) begin
          frame_active_next = 1'b1;
          bit_total_next    = 8'd0;
          repeat_count_next = 8'd0;
        end
      end
    end

    if (bit_total_next == KEY_BITS && bit_total != KEY_BITS) begin
      held_key_next  = bit_shift_next;
      bit_shift_next = 8'd0;
      key_latch      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= REG_RESET[i];
      end
      in_q_valid    <= 1'b0;
      out_valid     <= 1'b0;
      await_falling <= 1'b0;
      frame_active  <= 1'b0;
      silence_ticks <= 8'd0;
      bit_shift     <= 8'd0;
      bit_total     <= 8'd0;
      repeat_count  <= 8'd0;
      held_key      <= 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        regs[cfg_index] <= cfg_data;
      end
      if (in_valid && in_ready) begin
        in_q_valid <= 1'b1;
        in_q       <= in_data;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
      if (advance) begin
        out_valid              <= 1'b1;
        out_data.key_code      <= held_key_next;
        out_data.key_valid     <= key_latch;
        out_data.receiving     <= frame_active_next;
        out_data.repeat_total  <= repeat_count_next;
        out_data.bits_seen     <= bit_total_next;
        await_falling          <= await_falling_next;
        frame_active           <= frame_active_next;
        silence_ticks          <= silence_ticks_next;
        bit_shift              <= bit_shift_next;
        bit_total              <= bit_total_next;
        repeat_count           <= repeat_count_next;
        held_key               <= held_key_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/nec_ir_chk.sv]
`default_nettype none

module nec_ir_chk
  import nec_ir_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    in_ready,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire ir_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a key strobe only comes with a full frame still open
  a_key_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.key_valid |-> out_data.bits_seen == KEY_BITS && out_data.receiving)
    else $error("key strobe without a completed frame");

  // reset leaves nothing pending and the input open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // two strobes in a row would need bits_seen to leave and re-reach 24
  a_key_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.key_valid ##1 out_valid
      |-> !out_data.key_valid)
    else $error("key strobed on consecutive results");

endmodule

bind nec_ir_pulse_decoder nec_ir_chk u_nec_ir_chk (.*);

`default_nettype wire

[tb/testbench.sv]
module testbench;
  import nec_ir_pkg::*;

  // request code the block treats as no event
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef logic [REG_BITS-1:0] bounds_t [NUM_REGS];

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  ir_in_t in_data;
  logic out_valid;
  logic out_ready;
  ir_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0] cfg_data;

  // decoder state as the testbench expects it
  bounds_t window_bounds = REG_RESET;
  logic want_falling = 1'b0;
  logic frame_open = 1'b0;
  logic [7:0] quiet_ticks = '0;
  logic [7:0] shift_bits = '0;
  logic [7:0] bit_tally = '0;
  logic [7:0] repeat_tally = '0;
  logic [7:0] latched_key = '0;

  ir_out_t pending_results[$];
  int requests_sent = 0;
  int mismatch_count = 0;
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;

  nec_ir_pulse_decoder #(.CAPTURE_WIDTH(CAP_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic bit in_window(input logic [CAP_BITS-1:0] width,
                                   input logic [IDX_BITS-1:0] lo_idx);
    return width > window_bounds[lo_idx] && width < window_bounds[lo_idx + IDX_BITS'(1)];
  endfunction

  // Advances the expected state by one request and returns its result.
  function automatic ir_out_t decode_request(input ir_in_t req);
    ir_out_t res;
    logic [7:0] bits_prior;
    bits_prior = bit_tally;
    res.key_valid = 1'b0;
    if (req.req_type == REQ_TICK || req.req_type == REQ_TICK_EDGE) begin
      if (frame_open) begin
        if (quiet_ticks > SILENCE_FIRST &&
            (repeat_tally == 8'd0 || quiet_ticks > SILENCE_LAST))
          frame_open = 1'b0;
        quiet_ticks = sat_inc(quiet_ticks);
      end
    end
    if (req.req_type == REQ_EDGE || req.req_type == REQ_TICK_EDGE) begin
      if (!want_falling) begin
        want_falling = 1'b1;
        quiet_ticks = '0;
      end else begin
        want_falling = 1'b0;
        if (frame_open) begin
          // zero checked before one before repeat where windows overlap
          if (in_window(req.capture_count, REG_ZERO_MIN)) begin
            shift_bits = {shift_bits[6:0], 1'b0};
            bit_tally = sat_inc(bit_tally);
          end else if (in_window(req.capture_count, REG_ONE_MIN)) begin
            shift_bits = {shift_bits[6:0], 1'b1};
            bit_tally = sat_inc(bit_tally);
          end else if (in_window(req.capture_count, REG_REPEAT_MIN)) begin
            if (repeat_tally > REPEAT_SKIP)
              bit_tally = sat_inc(bit_tally);
            repeat_tally = sat_inc(repeat_tally);
          end
        end else if (in_window(req.capture_count, REG_LEADER_MIN)) begin
          frame_open = 1'b1;
          bit_tally = '0;
          repeat_tally = '0;
        end
      end
    end
    if (bit_tally == KEY_BITS && bits_prior != KEY_BITS) begin
      latched_key = shift_bits;
      shift_bits = '0;
      res.key_valid = 1'b1;
    end
    res.key_code = latched_key;
    res.receiving = frame_open;
    res.repeat_total = repeat_tally;
    res.bits_seen = bit_tally;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    ir_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_data.key_code !== want.key_code)
          report_mismatch($sformatf("key_code %0h, expected %0h",
                                    out_data.key_code, want.key_code));
        if (out_data.key_valid !== want.key_valid)
          report_mismatch($sformatf("key_valid %0b, expected %0b",
                                    out_data.key_valid, want.key_valid));
        if (out_data.receiving !== want.receiving)
          report_mismatch($sformatf("receiving %0b, expected %0b",
                                    out_data.receiving, want.receiving));
        if (out_data.repeat_total !== want.repeat_total)
          report_mismatch($sformatf("repeat_total %0d, expected %0d",
                                    out_data.repeat_total, want.repeat_total));
        if (out_data.bits_seen !== want.bits_seen)
          report_mismatch($sformatf("bits_seen %0d, expected %0d",
                                    out_data.bits_seen, want.bits_seen));
      end
    end
  end

  // Called and returns just after a falling edge; valid is left high after
  // acceptance so that back-to-back requests follow with no gap in valid.
  task automatic send_item(input logic [1:0] kind, input logic [CAP_BITS-1:0] count);
    ir_in_t req;
    req.req_type = kind;
    req.capture_count = count;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(decode_request(req));
    requests_sent++;
    @(negedge clk);
  endtask

  function automatic logic [1:0] edge_kind();
    return ($urandom_range(3) == 0) ? REQ_TICK_EDGE : REQ_EDGE;
  endfunction

  task automatic send_noise();
    send_item(2'($urandom_range(3)), CAP_BITS'($urandom_range(16'hFFFF)));
  endtask

  // one high pulse: rising edge if due, then falling edge with the width
  task automatic send_pulse(input logic [CAP_BITS-1:0] width);
    if (!want_falling)
      send_item(edge_kind(), CAP_BITS'($urandom_range(16'hFFFF)));
    send_item(edge_kind(), width);
  endtask

  function automatic logic [CAP_BITS-1:0] pick_width(input logic [IDX_BITS-1:0] lo_idx,
                                                     input bit exact);
    int lo;
    int hi;
    lo = int'(window_bounds[lo_idx]);
    hi = int'(window_bounds[lo_idx + IDX_BITS'(1)]);
    if (hi > lo + 1 && (exact || $urandom_range(9) > 2))
      return CAP_BITS'($urandom_range(hi - 1, lo + 1));
    case ($urandom_range(2))
      0: return CAP_BITS'(lo);
      1: return CAP_BITS'(hi);
      default: return CAP_BITS'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic load_windows(input bounds_t w);
    drain_results();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= IDX_BITS'(i);
      cfg_data <= w[i];
      do @(posedge clk); while (!cfg_ready);
      window_bounds[i] = w[i];
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic bounds_t random_windows();
    bounds_t w;
    int pt;
    pt = $urandom_range(400);
    for (int i = 0; i < NUM_REGS; i++) begin
      w[i] = REG_BITS'(pt);
      pt += (i % 2 == 0) ? $urandom_range(900, 2) : $urandom_range(600);
    end
    return w;
  endfunction

  task automatic set_idling(input int gap_pct, input int stall_pct);
    sender_gap_pct = gap_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // leader, bits with occasional noise, repeats, then silence that may or may not close the frame
  task automatic play_frame();
    int n_bits;
    int n_repeats;
    int n_ticks;
    n_bits = $urandom_range(28, 16);
    n_repeats = $urandom_range(8);
    n_ticks = ($urandom_range(3) == 0) ? $urandom_range(6) : $urandom_range(12, 10);
    send_pulse(pick_width(REG_LEADER_MIN, 1'b0));
    repeat (n_bits) begin
      if ($urandom_range(24) == 0)
        send_noise();
      send_pulse(pick_width($urandom_range(1) ? REG_ONE_MIN : REG_ZERO_MIN, 1'b0));
    end
    repeat (n_repeats) send_pulse(pick_width(REG_REPEAT_MIN, 1'b0));
    repeat (n_ticks) send_item(REQ_TICK, CAP_BITS'($urandom_range(16'hFFFF)));
  endtask

  task automatic run_frames(input int count);
    int stop;
    stop = requests_sent + count;
    while (requests_sent < stop) begin
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(4, 1)) send_noise();
      play_frame();
    end
  endtask

  task automatic test_directed_pulses();
    send_item(REQ_NONE, 16'hFFFF);
    send_item(REQ_TICK, 16'h0000);
    send_pulse(window_bounds[REG_LEADER_MIN]);
    send_item(REQ_EDGE, 16'h5A5A);
    send_item(REQ_TICK_EDGE, window_bounds[REG_LEADER_MIN] + 16'd1);
    send_pulse(window_bounds[REG_ZERO_MIN]);
    send_pulse(window_bounds[REG_ZERO_MIN] + 16'd1);
    send_pulse(window_bounds[REG_ONE_MAX] - 16'd1);
    send_pulse(window_bounds[REG_REPEAT_MIN] + 16'd1);
    send_pulse(16'hFFFF);
    // with a repeat seen the frame closes on the tenth or eleventh quiet tick
    repeat (11) send_item(REQ_TICK, CAP_BITS'($urandom_range(16'hFFFF)));
  endtask

  task automatic test_key_frames(input bounds_t w, input int count);
    load_windows(w);
    run_frames(count);
  endtask

  task automatic test_overlapping_windows(input int count);
    load_windows('{16'd0, 16'd1000, 16'd500, 16'd2000, 16'd1500, 16'd3000,
                   16'd100, 16'd60000});
    run_frames(count);
  endtask

  task automatic test_closed_windows(input int count);
    load_windows('{default: 16'h0000});
    run_frames(count);
    load_windows('{default: 16'hFFFF});
    run_frames(count);
  endtask

  task automatic test_counter_saturation();
    load_windows('{16'd0, 16'd800, 16'd1400, 16'd1800, 16'd2100, 16'd2500,
                   16'd4200, 16'hFFFF});
    send_pulse(pick_width(REG_LEADER_MIN, 1'b1));
    repeat (258) send_pulse(pick_width(REG_REPEAT_MIN, 1'b1));
    repeat (8) send_pulse(pick_width($urandom_range(1) ? REG_ONE_MIN : REG_ZERO_MIN, 1'b1));
    repeat (12) send_item(REQ_TICK, CAP_BITS'($urandom_range(16'hFFFF)));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_directed_pulses();
    set_idling(0, 0);
    test_key_frames(random_windows(), 60);
    set_idling(52, 0);
    test_key_frames(random_windows(), 60);
    set_idling(0, 52);
    test_key_frames(REG_RESET, 60);
    set_idling(10, 10);
    test_overlapping_windows(60);
    test_closed_windows(40);
    test_counter_saturation();

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
